[design/npcm_pkg.sv]
// Shared types and constants for the nearest palette color match block.
// No dependencies; used by npcm_sqrt and nearest_palette_color_match.
package npcm_pkg;

   localparam int ENTRIES_DEF = 256;
   localparam int COLOR_W     = 24;
   localparam int CHAN_W      = 8;
   localparam int INDEX_W     = 8;
   localparam int SIZE_W      = 9;
   localparam int DIST_W      = 18;
   localparam int ROOT_W      = 9;
   localparam int SECOND_W    = 16;

   localparam logic [SIZE_W-1:0]   SIZE_RESET  = 9'd256;
   localparam logic [SECOND_W-1:0] SECOND_NONE = 16'hFFFF;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_SQRT_BEST,
      ST_SQRT_SECOND,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } sqrt_status_type;

endpackage

[design/npcm_sqrt.sv]
// Iterative floor square root, one result bit per cycle.
// Depends on npcm_pkg for widths and the status struct.
module npcm_sqrt (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [npcm_pkg::DIST_W-1:0]      value,
   output logic [npcm_pkg::ROOT_W-1:0]      root,
   output npcm_pkg::sqrt_status_type        status
);

   localparam int IN_W  = npcm_pkg::DIST_W;
   localparam int RT_W  = npcm_pkg::ROOT_W;
   localparam int REM_W = RT_W + 2;
   localparam int CNT_W = $clog2(RT_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [IN_W-1:0]  data_ff, data_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [RT_W-1:0]  root_ff, root_in;
   logic [REM_W-1:0] rem_shift;
   logic [REM_W-1:0] trial;

   always_comb begin
      rem_shift = {rem_ff[REM_W-3:0], data_ff[IN_W-1 -: 2]};
      trial     = {root_ff, 2'b01};
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      data_in   = data_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(RT_W - 1);
         data_in = value;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         // bring down two bits, try the next root bit
         data_in = {data_ff[IN_W-3:0], 2'b00};
         if (rem_shift >= trial) begin
            rem_in  = rem_shift - trial;
            root_in = {root_ff[RT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_shift;
            root_in = {root_ff[RT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      data_ff <= data_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign root        = root_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

[design/nearest_palette_color_match.sv]
// Nearest palette color match: palette memory, scan sequencer and result register.
// Depends on npcm_pkg and npcm_sqrt.
// A write request completes at its accept and leaves the block idle. A query over n entries
// makes n memory reads, drains the distance pipeline, then roots the best distance and, if a
// runner-up exists, the runner-up distance in the one shared root unit. An empty palette
// skips the scan and roots. One request is in work at a time; req_ready returns once the
// response moves into the result register, later while rsp_ready holds it back.
// Reset sets palette_size to 256 and clears control; palette contents stay undefined.
module nearest_palette_color_match #(
   parameter int ENTRIES = npcm_pkg::ENTRIES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_kind,
   input  logic [npcm_pkg::INDEX_W-1:0]        req_entry_index,
   input  logic [npcm_pkg::COLOR_W-1:0]        req_color,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [npcm_pkg::INDEX_W-1:0]        rsp_best_index,
   output logic [npcm_pkg::INDEX_W-1:0]        rsp_second_index,
   output logic [npcm_pkg::ROOT_W-1:0]         rsp_best_error,
   output logic [npcm_pkg::SECOND_W-1:0]       rsp_second_error,
   output logic                                rsp_empty_res,
   input  logic                                csr_wr_en,
   input  logic [npcm_pkg::SIZE_W-1:0]         csr_wr_data
);

   localparam int AW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW    = AW + 1;
   localparam int CMP_W = (CW > npcm_pkg::SIZE_W) ? CW : npcm_pkg::SIZE_W;
   localparam int DW    = npcm_pkg::DIST_W + 1;
   localparam int CH    = npcm_pkg::CHAN_W;
   localparam int SQ_W  = 2 * npcm_pkg::CHAN_W;

   localparam logic [DW-1:0] DIST_NONE = '1;

   npcm_pkg::state_type state_ff, state_in;

   logic [npcm_pkg::SIZE_W-1:0]   size_ff;
   logic [npcm_pkg::COLOR_W-1:0]  palette_mem [ENTRIES];
   logic [npcm_pkg::COLOR_W-1:0]  rd_data_ff;
   logic [npcm_pkg::COLOR_W-1:0]  q_ff;
   logic [CW-1:0]                 cnt_ff;
   logic [CW-1:0]                 n_ff;
   logic [CW-1:0]                 n_sat;
   logic                          v1_ff, v2_ff;
   logic [AW-1:0]                 idx1_ff, idx2_ff;
   logic [SQ_W-1:0]               sq_r_ff, sq_g_ff, sq_b_ff;
   logic [DW-1:0]                 dist_sum;
   logic [DW-1:0]                 bd0_ff, bd1_ff;
   logic [AW-1:0]                 bi0_ff, bi1_ff;
   logic [npcm_pkg::ROOT_W-1:0]   be_ff;
   logic [npcm_pkg::SECOND_W-1:0] se_ff;
   logic                          empty_ff;

   logic                          rsp_valid_ff;
   logic [npcm_pkg::INDEX_W-1:0]  rsp_best_index_ff, rsp_second_index_ff;
   logic [npcm_pkg::ROOT_W-1:0]   rsp_best_error_ff;
   logic [npcm_pkg::SECOND_W-1:0] rsp_second_error_ff;
   logic                          rsp_empty_res_ff;

   logic                          req_fire, query_go, mem_we, rsp_load;
   logic                          sqrt_start;
   logic [npcm_pkg::DIST_W-1:0]   sqrt_value;
   logic [npcm_pkg::ROOT_W-1:0]   sqrt_root;
   npcm_pkg::sqrt_status_type     sqrt_status;

   function automatic logic [SQ_W-1:0] chan_sq(input logic [CH-1:0] a,
                                               input logic [CH-1:0] b);
      logic [CH-1:0] d;
      d = (a > b) ? (a - b) : (b - a);
      return SQ_W'(d) * SQ_W'(d);
   endfunction

   assign req_ready = (state_ff == npcm_pkg::ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign query_go  = req_fire && (req_kind == npcm_pkg::KIND_QUERY);
   assign mem_we    = req_fire && (req_kind == npcm_pkg::KIND_WRITE) &&
                      (CMP_W'(req_entry_index) < CMP_W'(ENTRIES));
   assign rsp_load  = (state_ff == npcm_pkg::ST_RESP) && (!rsp_valid_ff || rsp_ready);

   // saturate the configured size to the store depth
   assign n_sat = (CMP_W'(size_ff) > CMP_W'(ENTRIES)) ? CW'(ENTRIES) : CW'(size_ff);

   assign dist_sum = DW'(sq_r_ff) + DW'(sq_g_ff) + DW'(sq_b_ff);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         palette_mem[AW'(req_entry_index)] <= req_color;
      end
      if (state_ff == npcm_pkg::ST_SCAN) begin
         rd_data_ff <= palette_mem[cnt_ff[AW-1:0]];
      end
   end

   npcm_sqrt u_sqrt (
      .clock  (clock),
      .reset  (reset),
      .start  (sqrt_start),
      .value  (sqrt_value),
      .root   (sqrt_root),
      .status (sqrt_status)
   );

   always_comb begin
      state_in   = state_ff;
      sqrt_start = 1'b0;
      sqrt_value = bd0_ff[npcm_pkg::DIST_W-1:0];
      case (state_ff)
         npcm_pkg::ST_IDLE: begin
            if (query_go) begin
               state_in = (n_sat == '0) ? npcm_pkg::ST_RESP : npcm_pkg::ST_SCAN;
            end
         end
         npcm_pkg::ST_SCAN: begin
            if (cnt_ff == n_ff - CW'(1)) begin
               state_in = npcm_pkg::ST_DRAIN;
            end
         end
         npcm_pkg::ST_DRAIN: begin
            // wait for the last distance to land, then root the best one
            if (!v1_ff && !v2_ff) begin
               sqrt_start = 1'b1;
               state_in   = npcm_pkg::ST_SQRT_BEST;
            end
         end
         npcm_pkg::ST_SQRT_BEST: begin
            if (sqrt_status.done) begin
               if (bd1_ff == DIST_NONE) begin
                  state_in = npcm_pkg::ST_RESP;
               end else begin
                  sqrt_start = 1'b1;
                  sqrt_value = bd1_ff[npcm_pkg::DIST_W-1:0];
                  state_in   = npcm_pkg::ST_SQRT_SECOND;
               end
            end
         end
         npcm_pkg::ST_SQRT_SECOND: begin
            if (sqrt_status.done) begin
               state_in = npcm_pkg::ST_RESP;
            end
         end
         npcm_pkg::ST_RESP: begin
            if (rsp_load) begin
               state_in = npcm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = npcm_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= npcm_pkg::ST_IDLE;
         size_ff      <= npcm_pkg::SIZE_RESET;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         bd0_ff       <= DIST_NONE;
         bd1_ff       <= DIST_NONE;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            size_ff <= csr_wr_data;
         end
         v1_ff <= (state_ff == npcm_pkg::ST_SCAN);
         v2_ff <= v1_ff;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (query_go) begin
            bd0_ff <= DIST_NONE;
            bd1_ff <= DIST_NONE;
         end else if (v2_ff) begin
            // strict less-than keeps the lower index on ties
            if (dist_sum < bd0_ff) begin
               bd1_ff <= bd0_ff;
               bd0_ff <= dist_sum;
            end else if (dist_sum < bd1_ff) begin
               bd1_ff <= dist_sum;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      idx1_ff <= cnt_ff[AW-1:0];
      idx2_ff <= idx1_ff;
      sq_r_ff <= chan_sq(q_ff[23:16], rd_data_ff[23:16]);
      sq_g_ff <= chan_sq(q_ff[15:8],  rd_data_ff[15:8]);
      sq_b_ff <= chan_sq(q_ff[7:0],   rd_data_ff[7:0]);
      if (query_go) begin
         cnt_ff   <= '0;
         n_ff     <= n_sat;
         q_ff     <= req_color;
         bi0_ff   <= '0;
         bi1_ff   <= '0;
         be_ff    <= '0;
         se_ff    <= '0;
         empty_ff <= (n_sat == '0);
      end else begin
         if (state_ff == npcm_pkg::ST_SCAN) begin
            cnt_ff <= cnt_ff + CW'(1);
         end
         if (v2_ff) begin
            if (dist_sum < bd0_ff) begin
               bi1_ff <= bi0_ff;
               bi0_ff <= idx2_ff;
            end else if (dist_sum < bd1_ff) begin
               bi1_ff <= idx2_ff;
            end
         end
         if ((state_ff == npcm_pkg::ST_SQRT_BEST) && sqrt_status.done) begin
            be_ff <= sqrt_root;
            if (bd1_ff == DIST_NONE) begin
               se_ff <= npcm_pkg::SECOND_NONE;
            end
         end
         if ((state_ff == npcm_pkg::ST_SQRT_SECOND) && sqrt_status.done) begin
            se_ff <= npcm_pkg::SECOND_W'(sqrt_root);
         end
      end
      if (rsp_load) begin
         rsp_best_index_ff   <= npcm_pkg::INDEX_W'(bi0_ff);
         rsp_second_index_ff <= npcm_pkg::INDEX_W'(bi1_ff);
         rsp_best_error_ff   <= be_ff;
         rsp_second_error_ff <= se_ff;
         rsp_empty_res_ff    <= empty_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_best_index   = rsp_best_index_ff;
   assign rsp_second_index = rsp_second_index_ff;
   assign rsp_best_error   = rsp_best_error_ff;
   assign rsp_second_error = rsp_second_error_ff;
   assign rsp_empty_res    = rsp_empty_res_ff;

   a_best_not_worse: assert property (@(posedge clock) disable iff (reset)
      bd0_ff <= bd1_ff)
      else $error("best distance above runner-up distance");

   a_root_done_in_root_state: assert property (@(posedge clock) disable iff (reset)
      sqrt_status.done |-> (state_ff == npcm_pkg::ST_SQRT_BEST ||
                            state_ff == npcm_pkg::ST_SQRT_SECOND))
      else $error("square root finished outside a root state");

   a_update_during_scan: assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> (state_ff == npcm_pkg::ST_SCAN || state_ff == npcm_pkg::ST_DRAIN))
      else $error("distance update outside the scan");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_empty_res_ff) |->
         (rsp_best_error_ff == '0 && rsp_second_error_ff == '0))
      else $error("empty result carries nonzero error");

endmodule
